/* design/set_assoc_cache_lru_sim_macros.svh */
// Assertion macros shared by the cache lookup RTL.
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/sacl_pkg.sv */
// Shared types and constants of the set-associative cache lookup block.
package sacl_pkg;

	// Access kinds
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_SET_INDEX_BITS = 2'd0;
	localparam logic [1:0] CFG_OFFSET_BITS    = 2'd1;
	localparam logic [1:0] CFG_WAYS_IN_USE    = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam int SET_BITS_W = 3;
	localparam int OFF_BITS_W = 6;
	localparam int WAYS_CFG_W = 4;

	// Set index before the modulo: at most seven index bits
	localparam int RAW_SET_W = 7;
	localparam int RAW_SETS  = 128;
	localparam int SHIFT_W   = 7;

	localparam int CNT_W = 32;

	typedef struct packed {
		logic hit;
		logic miss;
		logic evict;
	} lookup_t;

endpackage

/* design/sacl_channels.sv */
// Handshake channels: access requests, lookup results and configuration writes.
interface sacl_req_if import sacl_pkg::*; #(
	parameter int ADDR_WIDTH = 64
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            opcode;
	logic [ADDR_WIDTH-1:0] address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink (input valid, input opcode, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*;;
	logic             valid;
	logic             ready;
	logic             was_hit;
	logic             was_miss;
	logic             was_eviction;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;
	logic [CNT_W-1:0] eviction_total;

	modport source (output valid, output was_hit, output was_miss, output was_eviction,
		output hit_total, output miss_total, output eviction_total, input ready);
	modport sink (input valid, input was_hit, input was_miss, input was_eviction,
		input hit_total, input miss_total, input eviction_total, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/sacl_tag_store.sv */
// Tag and recency memories, one row per set, with per-row initialized flags.
module sacl_tag_store import sacl_pkg::*; #(
	parameter int MAX_SETS = 64,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_WIDTH = 64,
	localparam int SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
	localparam int RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [SetW-1:0]                      rd_set,
	output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tags,
	output logic [MAX_WAYS-1:0]                  rd_valid,
	output logic [MAX_WAYS-1:0][RankW-1:0]       rd_ranks,
	input  logic                                 wr_en,
	input  logic [SetW-1:0]                      wr_set,
	input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  wr_tags,
	input  logic [MAX_WAYS-1:0]                  wr_valid,
	input  logic [MAX_WAYS-1:0][RankW-1:0]       wr_ranks
);

	typedef struct packed {
		logic [MAX_WAYS-1:0]            valid;
		logic [MAX_WAYS-1:0][RankW-1:0] ranks;
	} meta_row_t;

	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [MAX_SETS];
	meta_row_t                           meta_mem [MAX_SETS];

	logic [MAX_SETS-1:0]                 row_init_q;
	logic                                rd_init_q;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_rd_q;
	meta_row_t                           meta_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_set]  <= wr_tags;
			meta_mem[wr_set] <= '{valid: wr_valid, ranks: wr_ranks};
		end
		if (rd_en) begin
			tag_rd_q  <= tag_mem[rd_set];
			meta_rd_q <= meta_mem[rd_set];
		end
	end

	// A row never written reads as all invalid with rank equal to way number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			rd_init_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_init_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= row_init_q[rd_set];
			end
		end
	end

	always_comb begin
		rd_tags = tag_rd_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			rd_valid[w] = rd_init_q & meta_rd_q.valid[w];
			rd_ranks[w] = rd_init_q ? meta_rd_q.ranks[w] : RankW'(w);
		end
	end

endmodule

/* design/sacl_way_select.sv */
// Compare one set across its ways, pick hit, free or LRU way, and build the updated row.
module sacl_way_select import sacl_pkg::*; #(
	parameter int MAX_WAYS = 8,
	parameter int ADDR_WIDTH = 64,
	localparam int RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int WaysW = $clog2(MAX_WAYS + 1)
) (
	input  logic [ADDR_WIDTH-1:0]                tag,
	input  logic [WaysW-1:0]                     ways,
	input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tags,
	input  logic [MAX_WAYS-1:0]                  rd_valid,
	input  logic [MAX_WAYS-1:0][RankW-1:0]       rd_ranks,
	output lookup_t                              res,
	output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  new_tags,
	output logic [MAX_WAYS-1:0]                  new_valid,
	output logic [MAX_WAYS-1:0][RankW-1:0]       new_ranks
);

	localparam int WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] hit_vec;
	logic [MAX_WAYS-1:0] free_vec;
	logic [WayW-1:0]     hit_way;
	logic [WayW-1:0]     free_way;
	logic [WayW-1:0]     lru_way;
	logic [RankW-1:0]    lru_rank;
	logic [WayW-1:0]     sel_way;
	logic [RankW-1:0]    old_rank;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]   = WaysW'(w) < ways;
			hit_vec[w]  = in_use[w] & rd_valid[w] & (rd_tags[w] == tag);
			free_vec[w] = in_use[w] & ~rd_valid[w];
		end

		// Lowest-numbered match wins: scan downward
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WayW'(w);
			end
			if (free_vec[w]) begin
				free_way = WayW'(w);
			end
		end

		// Victim: highest rank among ways in use, lowest way on a tie
		lru_way  = '0;
		lru_rank = rd_ranks[0];
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && rd_ranks[w] > lru_rank) begin
				lru_rank = rd_ranks[w];
				lru_way  = WayW'(w);
			end
		end

		res.hit   = |hit_vec;
		res.miss  = ~res.hit;
		res.evict = ~res.hit & ~(|free_vec);

		priority if (res.hit) begin
			sel_way = hit_way;
		end else if (!res.evict) begin
			sel_way = free_way;
		end else begin
			sel_way = lru_way;
		end

		// Move the chosen way to rank zero, age the younger ones
		old_rank = rd_ranks[sel_way];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WayW'(w) == sel_way) begin
				new_ranks[w] = '0;
				new_tags[w]  = tag;
				new_valid[w] = 1'b1;
			end else begin
				new_ranks[w] = (rd_ranks[w] < old_rank) ? rd_ranks[w] + RankW'(1) : rd_ranks[w];
				new_tags[w]  = rd_tags[w];
				new_valid[w] = rd_valid[w];
			end
		end
	end

endmodule

/* design/set_assoc_cache_lru_sim.sv */
// A request's set row is read in the accept cycle (read, then update); the update writes the
// row back and loads the result register, and no new access is taken while that row is
// being updated.
// A result waiting on a stalled consumer holds the update stage until it is transferred.
// Reset clears the counters, configuration (0 index bits, 0 offset bits, 1 way) and the
// per-set initialized flags at once, so no clearing pass is needed after reset.
module set_assoc_cache_lru_sim import sacl_pkg::*; #(
	parameter int MAX_SETS = 64,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_WIDTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	sacl_cfg_if.sink  cfg,
	sacl_req_if.sink  req,
	sacl_rsp_if.source rsp
);

`include "set_assoc_cache_lru_sim_macros.svh"

	localparam int SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WaysW = $clog2(MAX_WAYS + 1);

	// Configuration registers
	logic [SET_BITS_W-1:0] set_bits_q;
	logic [OFF_BITS_W-1:0] off_bits_q;
	logic [WAYS_CFG_W-1:0] ways_q;
	logic [WaysW-1:0]      ways_eff;

	// Address split
	logic [SHIFT_W-1:0]    tag_shift;
	logic [RAW_SET_W-1:0]  set_mask;
	logic [RAW_SET_W-1:0]  set_raw;
	logic [SetW-1:0]       set_in;
	logic [ADDR_WIDTH-1:0] tag_in;
	logic [SetW-1:0]       mod_lut [RAW_SETS];

	// Lookup stage
	logic                  busy_q;
	logic                  accept_in;
	logic                  finish_s1;
	logic                  write_s1;
	opcode_t               op_s1;
	logic [SetW-1:0]       set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;

	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags;
	logic [MAX_WAYS-1:0]                 rd_valid;
	logic [MAX_WAYS-1:0][RankW-1:0]      rd_ranks;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tags;
	logic [MAX_WAYS-1:0]                 new_valid;
	logic [MAX_WAYS-1:0][RankW-1:0]      new_ranks;
	lookup_t                             res;

	// Result register and running counters
	logic                  out_valid_q;
	lookup_t               flags_q;
	logic [CNT_W-1:0]      hit_cnt_q;
	logic [CNT_W-1:0]      miss_cnt_q;
	logic [CNT_W-1:0]      evict_cnt_q;

	// ---------------------------------------------------------------------
	// Configuration: always ready, take the low bits of the data
	// ---------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= '0;
			off_bits_q <= '0;
			ways_q     <= WAYS_CFG_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SET_INDEX_BITS: set_bits_q <= cfg.data[SET_BITS_W-1:0];
				CFG_OFFSET_BITS:    off_bits_q <= cfg.data[OFF_BITS_W-1:0];
				CFG_WAYS_IN_USE:    ways_q     <= cfg.data[WAYS_CFG_W-1:0];
				default: begin
					// Unknown index: drop the write
				end
			endcase
		end
	end

	// Zero ways acts as one; clamp anything above the built associativity
	always_comb begin
		priority if (ways_q == '0) begin
			ways_eff = WaysW'(1);
		end else if ({1'b0, ways_q} > (WAYS_CFG_W + 1)'(MAX_WAYS)) begin
			ways_eff = WaysW'(MAX_WAYS);
		end else begin
			ways_eff = WaysW'(ways_q);
		end
	end

	// ---------------------------------------------------------------------
	// Address split: offset, set index (wrapped to the built set count), tag
	// ---------------------------------------------------------------------
	for (genvar i = 0; i < RAW_SETS; i++) begin : g_set_wrap
		assign mod_lut[i] = SetW'(i % MAX_SETS);
	end

	assign tag_shift = SHIFT_W'(off_bits_q) + SHIFT_W'(set_bits_q);
	assign set_mask  = RAW_SET_W'((8'd1 << set_bits_q) - 8'd1);
	assign set_raw   = RAW_SET_W'(req.address >> off_bits_q) & set_mask;
	assign set_in    = mod_lut[set_raw];
	// A shift at or past the address width yields a zero tag
	assign tag_in    = req.address >> tag_shift;

	// ---------------------------------------------------------------------
	// Control: accept one access, read its set, then update it.
	// The update waits while the result register is still full.
	// ---------------------------------------------------------------------
	assign req.ready = ~busy_q;
	assign accept_in = req.valid & req.ready;
	assign finish_s1 = busy_q & (~out_valid_q | rsp.ready);
	assign write_s1  = finish_s1 & (op_s1 != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept_in) begin
			busy_q <= 1'b1;
		end else if (finish_s1) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_s1  <= opcode_t'(req.opcode);
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
	end

	sacl_tag_store #(
		.MAX_SETS   (MAX_SETS),
		.MAX_WAYS   (MAX_WAYS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept_in),
		.rd_set   (set_in),
		.rd_tags  (rd_tags),
		.rd_valid (rd_valid),
		.rd_ranks (rd_ranks),
		.wr_en    (write_s1),
		.wr_set   (set_s1),
		.wr_tags  (new_tags),
		.wr_valid (new_valid),
		.wr_ranks (new_ranks)
	);

	sacl_way_select #(
		.MAX_WAYS   (MAX_WAYS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_select (
		.tag       (tag_s1),
		.ways      (ways_eff),
		.rd_tags   (rd_tags),
		.rd_valid  (rd_valid),
		.rd_ranks  (rd_ranks),
		.res       (res),
		.new_tags  (new_tags),
		.new_valid (new_valid),
		.new_ranks (new_ranks)
	);

	// ---------------------------------------------------------------------
	// Counters and result register. The counters only advance when a result
	// is loaded, which needs the result register free, so they drive the
	// totals of the waiting result directly.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (write_s1) begin
				// A modify adds a second hit for its store half
				hit_cnt_q   <= hit_cnt_q + CNT_W'(res.hit) + CNT_W'(op_s1 == OP_MODIFY);
				miss_cnt_q  <= miss_cnt_q + CNT_W'(res.miss);
				evict_cnt_q <= evict_cnt_q + CNT_W'(res.evict);
			end
			if (finish_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Unused opcode: report no hit, miss or eviction
	always_ff @(posedge clk) begin
		if (finish_s1) begin
			flags_q <= (op_s1 == OP_NONE) ? '0 : res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.was_hit        = flags_q.hit;
	assign rsp.was_miss       = flags_q.miss;
	assign rsp.was_eviction   = flags_q.evict;
	assign rsp.hit_total      = hit_cnt_q;
	assign rsp.miss_total     = miss_cnt_q;
	assign rsp.eviction_total = evict_cnt_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`SACL_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept_in, busy_q, "accepted access did not start a lookup")
	`SACL_ASSERT_NEXT(a_finish_loads, clk, arst_n, finish_s1, out_valid_q && !busy_q, "finished lookup did not load the result")
	`SACL_ASSERT_NEXT(a_stall_freezes, clk, arst_n, out_valid_q && !rsp.ready, out_valid_q && $stable(hit_cnt_q) && $stable(miss_cnt_q) && $stable(evict_cnt_q), "counters moved under a stalled result")
	`SACL_ASSERT_SAME(a_outcome, clk, arst_n, finish_s1, (res.hit != res.miss) && (!res.evict || res.miss), "inconsistent hit, miss and eviction flags")

endmodule
